FILE: rtl/pfl_pkg.sv
package pfl_pkg;

  // Field widths of the command and result words
  localparam int FUNC_W   = 3;
  localparam int PAGE_W   = 12;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 10;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DISPOSE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_NEXT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PREV    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CHECK   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLOSED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EOF     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [PAGE_W-1:0] page_number;
  } pfl_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_page;
  } pfl_out_t;

endpackage

FILE: rtl/pfl_link_mem.sv
module pfl_link_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pfl_ctrl.sv
module pfl_ctrl #(
  parameter int MAX_PAGES = 1024,
  parameter int AW        = 10,
  parameter int LW        = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             file_open,
  input  logic             start,
  input  pfl_pkg::pfl_in_t in_data,
  output logic             busy,
  output logic             out_valid,
  output pfl_pkg::pfl_out_t out_data,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [LW-1:0]    mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [LW-1:0]    mem_rdata
);
  import pfl_pkg::*;

  localparam int CMPW = ((LW > PAGE_W) ? LW : PAGE_W) + 1;
  localparam int SW   = CMPW + 1;

  localparam logic [LW-1:0] LINK_END  = LW'(MAX_PAGES);
  localparam logic [LW-1:0] LINK_USED = LW'(MAX_PAGES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [LW-1:0]        head_r, head_nxt;
  logic [LW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic signed [SW-1:0] cur_r, cur_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic                 dir_next_r, dir_next_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pfl_out_t             out_data_r, out_data_nxt;

  logic [PAGE_W-1:0]    pn;
  logic [CMPW-1:0]      pn_u;
  logic [CMPW-1:0]      count_u;
  logic                 pn_minus1;
  logic                 pn_in_range;
  logic                 pn_eq_count;
  logic [AW-1:0]        pn_addr;
  logic signed [SW-1:0] pn_s;
  logic signed [SW-1:0] count_s;
  logic                 head_avail;
  logic                 cur_in_bound;

  // Decode the page number against the current page count
  assign pn          = in_data.page_number;
  assign pn_u        = {{(CMPW-PAGE_W+1){1'b0}}, pn[PAGE_W-2:0]};
  assign count_u     = CMPW'(count_r);
  assign pn_minus1   = &pn;
  assign pn_in_range = !pn[PAGE_W-1] && (pn_u < count_u);
  assign pn_eq_count = !pn[PAGE_W-1] && (pn_u == count_u);
  assign pn_addr     = AW'(pn_u);
  assign pn_s        = $signed({{(SW-PAGE_W){pn[PAGE_W-1]}}, pn});
  assign count_s     = $signed(SW'(count_r));
  assign head_avail  = (head_r < count_r) && (head_r < LINK_END);
  assign cur_in_bound = dir_next_r ? (cur_r < count_s) : (cur_r >= $signed(SW'(0)));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    cur_nxt       = cur_r;
    pend_vld_nxt  = pend_vld_r;
    pend_addr_nxt = pend_addr_r;
    dir_next_nxt  = dir_next_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          if (in_data.func > FN_CHECK) begin
            out_data_nxt.status = ST_INVALID;
          end else if (!file_open) begin
            out_data_nxt.status = ST_CLOSED;
          end else begin
            case (in_data.func)
              FN_ALLOC: begin
                if (head_avail) begin
                  // pop the free-list head; its link becomes the new head
                  out_valid_nxt = 1'b0;
                  mem_re        = 1'b1;
                  mem_raddr     = AW'(head_r);
                  addr_nxt      = AW'(head_r);
                  state_nxt     = S_ALLOC;
                end else if (count_r >= LINK_END) begin
                  out_data_nxt.status = ST_FULL;
                end else begin
                  // grow the file by one page
                  mem_we        = 1'b1;
                  mem_waddr     = AW'(count_r);
                  mem_wdata     = LINK_USED;
                  count_nxt     = count_r + LW'(1);
                  out_data_nxt.status     = ST_OK;
                  out_data_nxt.found_page = FOUND_W'(count_r);
                end
              end
              FN_DISPOSE, FN_CHECK: begin
                if (pn_in_range) begin
                  out_valid_nxt = 1'b0;
                  mem_re        = 1'b1;
                  mem_raddr     = pn_addr;
                  addr_nxt      = pn_addr;
                  state_nxt     = (in_data.func == FN_DISPOSE) ? S_DISP : S_CHECK;
                end else begin
                  out_data_nxt.status = ST_INVALID;
                end
              end
              FN_NEXT, FN_PREV: begin
                if (pn_minus1 || pn_in_range || pn_eq_count) begin
                  out_valid_nxt = 1'b0;
                  dir_next_nxt  = (in_data.func == FN_NEXT);
                  cur_nxt       = (in_data.func == FN_NEXT) ? pn_s + SW'(1) : pn_s - SW'(1);
                  pend_vld_nxt  = 1'b0;
                  state_nxt     = S_SCAN;
                end else begin
                  out_data_nxt.status = ST_INVALID;
                end
              end
              default: begin
                out_data_nxt.status = ST_INVALID;
              end
            endcase
          end
        end
      end

      S_ALLOC: begin
        // mark the popped page used and advance the head
        head_nxt      = mem_rdata;
        mem_we        = 1'b1;
        mem_waddr     = addr_r;
        mem_wdata     = LINK_USED;
        out_valid_nxt = 1'b1;
        out_data_nxt.status     = ST_OK;
        out_data_nxt.found_page = FOUND_W'(addr_r);
        state_nxt     = S_IDLE;
      end

      S_DISP: begin
        out_valid_nxt = 1'b1;
        if (mem_rdata == LINK_USED) begin
          // push the page onto the free list
          mem_we        = 1'b1;
          mem_waddr     = addr_r;
          mem_wdata     = head_r;
          head_nxt      = LW'(addr_r);
          out_data_nxt.status     = ST_OK;
          out_data_nxt.found_page = FOUND_W'(addr_r);
        end else begin
          out_data_nxt.status = ST_FREE;
        end
        state_nxt = S_IDLE;
      end

      S_CHECK: begin
        out_valid_nxt = 1'b1;
        if (mem_rdata == LINK_USED) begin
          out_data_nxt.status     = ST_OK;
          out_data_nxt.found_page = FOUND_W'(addr_r);
        end else begin
          out_data_nxt.status = ST_INVALID;
        end
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        // check the word read last cycle; on no hit, read the next page while in bounds
        if (pend_vld_r && (mem_rdata == LINK_USED)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status     = ST_OK;
          out_data_nxt.found_page = FOUND_W'(pend_addr_r);
          state_nxt     = S_IDLE;
        end else if (cur_in_bound) begin
          mem_re        = 1'b1;
          mem_raddr     = AW'(cur_r);
          pend_vld_nxt  = 1'b1;
          pend_addr_nxt = AW'(cur_r);
          cur_nxt       = dir_next_r ? cur_r + SW'(1) : cur_r - SW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status = ST_EOF;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= LINK_END;
      count_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    cur_r       <= cur_nxt;
    pend_addr_r <= pend_addr_nxt;
    dir_next_r  <= dir_next_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result word only follows an accepted command or an operation in flight
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy || start))
    else $error("result word without a command");

  // The free-list head is the end marker or a page inside the file
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == LINK_END) || (head_r < count_r))
    else $error("free-list head out of range");

  // The page count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LINK_END)
    else $error("page count beyond capacity");

  // Scans never modify link words
  a_scan_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("link write during scan");

  // Only a successful result carries a page number
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.found_page == '0))
    else $error("page number on a failed result");

endmodule

FILE: rtl/page_free_list_allocator.sv
// Page free-list allocator.
// Command channel: drive in_data (func, page_number) with start high; the
// command is taken at a clock edge where start is high and busy is low.
// Result channel: out_valid pulses for one cycle with out_data (status,
// found_page); the receiver cannot stall, so it must take the word then.
// Exactly one result word is returned per command, in command order.
// Config: cfg_we writes cfg_wdata into the file-open bit; write it only
// while no command is in flight.
// Allocate by growth and all rejected commands raise out_valid at the
// accepting edge itself; allocate from the free list, dispose and check
// first make one read of the link memory, and a scan reads link words
// one word per cycle through the read port.
// busy stays high until the edge that raises out_valid; the next command
// can be taken at the following edge.
// Reset clears the page count, empties the free list and closes the file;
// the link memory is not cleared.
module page_free_list_allocator #(
  parameter int MAX_PAGES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              start,
  input  pfl_pkg::pfl_in_t  in_data,
  output logic              busy,
  output logic              out_valid,
  output pfl_pkg::pfl_out_t out_data
);
  import pfl_pkg::*;

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int LW = $clog2(MAX_PAGES + 2);

  logic          file_open_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;

  // Hold the file-open bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_open_r <= 1'b0;
    end else if (cfg_we) begin
      file_open_r <= cfg_wdata;
    end
  end

  pfl_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .AW        (AW),
    .LW        (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .file_open (file_open_r),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pfl_link_mem #(
    .DEPTH (MAX_PAGES),
    .AW    (AW),
    .DW    (LW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
